// ===== hw/rtl/bcw_pkg.sv =====
// Package with shared constants, codes and payload types of the corner weight generator.
`timescale 1ns / 1ps

package bcw_pkg;

  localparam int MAX_AXIS_POINTS = 4096;
  localparam int FRAC_W          = 16;
  localparam int STEP_FRAC       = 16;
  localparam int COORD_W         = 32;
  localparam int AXIS_W          = $clog2(MAX_AXIS_POINTS);
  localparam int PTS_W           = 13;
  localparam int MARGIN_W        = 4;
  localparam int INDEX_W         = 24;
  localparam int WEIGHT_W        = FRAC_W + 1;
  localparam int POS_W           = 2 * COORD_W - STEP_FRAC;
  localparam int CFG_IDX_W       = 3;
  localparam int HI_W            = PTS_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_Z_ORIGIN   = 3'd0,
    CFG_X_ORIGIN   = 3'd1,
    CFG_Z_STEP_INV = 3'd2,
    CFG_X_STEP_INV = 3'd3,
    CFG_Z_POINTS   = 3'd4,
    CFG_X_POINTS   = 3'd5,
    CFG_MARGIN     = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] z_coord;
    logic signed [COORD_W-1:0] x_coord;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          corner;
    logic [INDEX_W-1:0]  grid_index;
    logic [WEIGHT_W-1:0] weight;
    logic                out_of_bounds;
    logic                last;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin;
    logic [COORD_W-1:0]        inv;
    logic [AXIS_W-1:0]         hi;
    logic                      hi_ok;
    logic [MARGIN_W-1:0]       margin;
  } axis_cfg_t;

  typedef struct packed {
    logic              ok;
    logic [AXIS_W-1:0] ipart;
    logic [FRAC_W-1:0] frac;
  } axis_res_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } axis_en_t;

  typedef struct packed {
    logic                     oob;
    logic [3:0][INDEX_W-1:0]  idx;
    logic [3:0][WEIGHT_W-1:0] w;
  } corner_set_t;

endpackage

// ===== hw/rtl/bcw_cfg.sv =====
// Configuration registers and derived per-axis bounds.
`timescale 1ns / 1ps

module bcw_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [bcw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcw_pkg::COORD_W-1:0]      cfg_data,
  output bcw_pkg::axis_cfg_t               z_cfg,
  output bcw_pkg::axis_cfg_t               x_cfg,
  output logic [bcw_pkg::PTS_W-1:0]        stride
);

  logic [bcw_pkg::COORD_W-1:0]  z_origin_r, x_origin_r, z_inv_r, x_inv_r;
  logic [bcw_pkg::PTS_W-1:0]    z_points_r, x_points_r;
  logic [bcw_pkg::MARGIN_W-1:0] margin_r;
  logic [bcw_pkg::PTS_W-1:0]    z_clamp, x_clamp;
  logic [bcw_pkg::HI_W-1:0]     z_hi, x_hi, margin_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_origin_r <= '0;
      x_origin_r <= '0;
      z_inv_r    <= bcw_pkg::COORD_W'(65536);
      x_inv_r    <= bcw_pkg::COORD_W'(65536);
      z_points_r <= bcw_pkg::PTS_W'(bcw_pkg::MAX_AXIS_POINTS);
      x_points_r <= bcw_pkg::PTS_W'(bcw_pkg::MAX_AXIS_POINTS);
      margin_r   <= bcw_pkg::MARGIN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        bcw_pkg::CFG_Z_ORIGIN:   z_origin_r <= cfg_data;
        bcw_pkg::CFG_X_ORIGIN:   x_origin_r <= cfg_data;
        bcw_pkg::CFG_Z_STEP_INV: z_inv_r    <= cfg_data;
        bcw_pkg::CFG_X_STEP_INV: x_inv_r    <= cfg_data;
        bcw_pkg::CFG_Z_POINTS:   z_points_r <= cfg_data[bcw_pkg::PTS_W-1:0];
        bcw_pkg::CFG_X_POINTS:   x_points_r <= cfg_data[bcw_pkg::PTS_W-1:0];
        bcw_pkg::CFG_MARGIN:     margin_r   <= cfg_data[bcw_pkg::MARGIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    z_clamp = (z_points_r > bcw_pkg::PTS_W'(bcw_pkg::MAX_AXIS_POINTS))
              ? bcw_pkg::PTS_W'(bcw_pkg::MAX_AXIS_POINTS) : z_points_r;
    x_clamp = (x_points_r > bcw_pkg::PTS_W'(bcw_pkg::MAX_AXIS_POINTS))
              ? bcw_pkg::PTS_W'(bcw_pkg::MAX_AXIS_POINTS) : x_points_r;
    margin_ext = bcw_pkg::HI_W'(margin_r);
    z_hi = bcw_pkg::HI_W'(z_clamp) - bcw_pkg::HI_W'(1) - margin_ext;
    x_hi = bcw_pkg::HI_W'(x_clamp) - bcw_pkg::HI_W'(1) - margin_ext;

    z_cfg.origin = $signed(z_origin_r);
    z_cfg.inv    = z_inv_r;
    z_cfg.hi     = z_hi[bcw_pkg::AXIS_W-1:0];
    z_cfg.hi_ok  = $signed(z_hi) > $signed(margin_ext);
    z_cfg.margin = margin_r;

    x_cfg.origin = $signed(x_origin_r);
    x_cfg.inv    = x_inv_r;
    x_cfg.hi     = x_hi[bcw_pkg::AXIS_W-1:0];
    x_cfg.hi_ok  = $signed(x_hi) > $signed(margin_ext);
    x_cfg.margin = margin_r;

    stride = z_clamp;
  end

endmodule

// ===== hw/rtl/bcw_axis.sv =====
// Three-stage mapping of one coordinate to grid units with bounds check.
`timescale 1ns / 1ps

module bcw_axis (
  input  logic                              clk,
  input  bcw_pkg::axis_en_t                 en,
  input  logic signed [bcw_pkg::COORD_W-1:0] coord,
  input  bcw_pkg::axis_cfg_t                acfg,
  output bcw_pkg::axis_res_t                res
);

  logic [bcw_pkg::COORD_W:0]     diff_nxt;
  logic [bcw_pkg::COORD_W-1:0]   diff_r;
  logic                          neg1_r, neg2_r;
  logic [2*bcw_pkg::COORD_W-1:0] prod_nxt;
  logic [bcw_pkg::POS_W-1:0]     pos_r;
  logic [bcw_pkg::POS_W-1:0]     lo_lim, hi_lim;
  bcw_pkg::axis_res_t            res_nxt, res_r;

  always_comb begin
    diff_nxt = {coord[bcw_pkg::COORD_W-1], coord}
             - {acfg.origin[bcw_pkg::COORD_W-1], acfg.origin};
    prod_nxt = (2*bcw_pkg::COORD_W)'(diff_r) * (2*bcw_pkg::COORD_W)'(acfg.inv);
    lo_lim   = bcw_pkg::POS_W'(acfg.margin) << bcw_pkg::FRAC_W;
    hi_lim   = bcw_pkg::POS_W'(acfg.hi) << bcw_pkg::FRAC_W;
    res_nxt.ok    = !neg2_r && acfg.hi_ok && (pos_r > lo_lim) && (pos_r < hi_lim);
    res_nxt.ipart = pos_r[bcw_pkg::FRAC_W +: bcw_pkg::AXIS_W];
    res_nxt.frac  = pos_r[bcw_pkg::FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      diff_r <= diff_nxt[bcw_pkg::COORD_W-1:0];
      neg1_r <= diff_nxt[bcw_pkg::COORD_W];
    end
    if (en.s2) begin
      pos_r  <= prod_nxt[2*bcw_pkg::COORD_W-1:bcw_pkg::STEP_FRAC];
      neg2_r <= neg1_r;
    end
    if (en.s3) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== hw/rtl/bcw_corners.sv =====
// Corner indexes and bilinear weights of one point, one register stage.
`timescale 1ns / 1ps

module bcw_corners (
  input  logic                          clk,
  input  logic                          en,
  input  bcw_pkg::axis_res_t            zres,
  input  bcw_pkg::axis_res_t            xres,
  input  logic [bcw_pkg::PTS_W-1:0]     stride,
  output bcw_pkg::corner_set_t          cset
);

  localparam int BASE_W = bcw_pkg::AXIS_W + bcw_pkg::PTS_W + 1;
  localparam int PROD_W = 2 * bcw_pkg::WEIGHT_W;

  function automatic logic [bcw_pkg::WEIGHT_W-1:0] wmul(
    input logic [bcw_pkg::WEIGHT_W-1:0] a,
    input logic [bcw_pkg::WEIGHT_W-1:0] b
  );
    logic [PROD_W-1:0] p;
    p = PROD_W'(a) * PROD_W'(b) + (PROD_W'(1) << (bcw_pkg::FRAC_W - 1));
    return p[bcw_pkg::FRAC_W +: bcw_pkg::WEIGHT_W];
  endfunction

  logic [BASE_W-1:0]             base_full;
  logic [bcw_pkg::INDEX_W-1:0]   base, strd;
  logic [bcw_pkg::WEIGHT_W-1:0]  fz, fx, wz, wx;
  bcw_pkg::corner_set_t          cset_nxt, cset_r;

  always_comb begin
    base_full = BASE_W'(xres.ipart) * BASE_W'(stride) + BASE_W'(zres.ipart);
    base      = base_full[bcw_pkg::INDEX_W-1:0];
    strd      = bcw_pkg::INDEX_W'(stride);
    fz = bcw_pkg::WEIGHT_W'(zres.frac);
    fx = bcw_pkg::WEIGHT_W'(xres.frac);
    wz = (bcw_pkg::WEIGHT_W'(1) << bcw_pkg::FRAC_W) - fz;
    wx = (bcw_pkg::WEIGHT_W'(1) << bcw_pkg::FRAC_W) - fx;
    cset_nxt.oob    = !(zres.ok && xres.ok);
    cset_nxt.idx[0] = base;
    cset_nxt.idx[1] = base + bcw_pkg::INDEX_W'(1);
    cset_nxt.idx[2] = base + strd;
    cset_nxt.idx[3] = base + strd + bcw_pkg::INDEX_W'(1);
    cset_nxt.w[0]   = wmul(wz, wx);
    cset_nxt.w[1]   = wmul(fz, wx);
    cset_nxt.w[2]   = wmul(wz, fx);
    cset_nxt.w[3]   = wmul(fz, fx);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cset_r <= cset_nxt;
    end
  end

  assign cset = cset_r;

endmodule

// ===== hw/rtl/bcw_serial.sv =====
// Output register that sends a point's corner results one per cycle unless stalled.
`timescale 1ns / 1ps

module bcw_serial (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  set_valid,
  input  bcw_pkg::corner_set_t  cset,
  output logic                  set_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bcw_pkg::out_item_t    out_data
);

  logic [1:0]          cnt_r, cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  bcw_pkg::out_item_t  out_r, out_nxt;
  logic                load;

  always_comb begin
    load    = set_valid && (!out_valid_r || !out_stall);
    set_pop = load && (cset.oob || (cnt_r == 2'd3));

    if (cset.oob) begin
      out_nxt.corner        = 2'd0;
      out_nxt.grid_index    = '0;
      out_nxt.weight        = '0;
      out_nxt.out_of_bounds = 1'b1;
      out_nxt.last          = 1'b1;
    end else begin
      out_nxt.corner        = cnt_r;
      out_nxt.grid_index    = cset.idx[cnt_r];
      out_nxt.weight        = cset.w[cnt_r];
      out_nxt.out_of_bounds = 1'b0;
      out_nxt.last          = (cnt_r == 2'd3);
    end

    if (set_pop) begin
      cnt_nxt = 2'd0;
    end else if (load) begin
      cnt_nxt = cnt_r + 2'd1;
    end else begin
      cnt_nxt = cnt_r;
    end

    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/bilinear_corner_weight_generator_core.sv =====
// Top level of the bilinear corner weight generator.
`timescale 1ns / 1ps

// A point enters in any cycle in which in_stall is low and passes four
// register stages: offset from the origin, 32x32 multiply by the reciprocal
// spacing, bounds check, then corner index and weight calculation; the
// output register adds one more. Results leave one per cycle while out_stall
// is low: four per interior point (top-left, bottom-left, top-right,
// bottom-right, last set on the fourth) and one flagged result per
// out-of-bounds point, so the single-result output channel sustains one
// out-of-bounds point per cycle, while an interior point holds it for all
// four of its results. Stalls propagate back stage by stage, so empty
// stages still fill. Write configuration only while idle.
module bilinear_corner_weight_generator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bcw_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bcw_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [bcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bcw_pkg::COORD_W-1:0]    cfg_data
);

  bcw_pkg::axis_cfg_t    z_cfg, x_cfg;
  logic [bcw_pkg::PTS_W-1:0] stride;
  bcw_pkg::axis_res_t    zres, xres;
  bcw_pkg::corner_set_t  cset;
  bcw_pkg::axis_en_t     axis_en;
  logic                  v1_r, v2_r, v3_r, v4_r;
  logic                  rdy1, rdy2, rdy3, rdy4;
  logic                  set_pop;

  always_comb begin
    rdy4 = !v4_r || set_pop;
    rdy3 = !v3_r || rdy4;
    rdy2 = !v2_r || rdy3;
    rdy1 = !v1_r || rdy2;
    axis_en.s1 = rdy1;
    axis_en.s2 = rdy2;
    axis_en.s3 = rdy3;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  assign in_stall = !rdy1;

  bcw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .z_cfg     (z_cfg),
    .x_cfg     (x_cfg),
    .stride    (stride)
  );

  bcw_axis u_axis_z (
    .clk   (clk),
    .en    (axis_en),
    .coord (in_data.z_coord),
    .acfg  (z_cfg),
    .res   (zres)
  );

  bcw_axis u_axis_x (
    .clk   (clk),
    .en    (axis_en),
    .coord (in_data.x_coord),
    .acfg  (x_cfg),
    .res   (xres)
  );

  bcw_corners u_corners (
    .clk    (clk),
    .en     (rdy4),
    .zres   (zres),
    .xres   (xres),
    .stride (stride),
    .cset   (cset)
  );

  bcw_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .set_valid (v4_r),
    .cset      (cset),
    .set_pop   (set_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== verif/bcw_corner_checker.sv =====
// Checker for the corner weight generator: predicts the corner items of each point and compares.
`timescale 1ns / 1ps

module bcw_corner_checker
  import bcw_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COORD_W-1:0]    cfg_data,
  output int unsigned           corners_due,
  output int unsigned           error_count
);

  localparam logic [1:0] CORNER_TOP_LEFT     = 2'd0;
  localparam logic [1:0] CORNER_BOTTOM_LEFT  = 2'd1;
  localparam logic [1:0] CORNER_TOP_RIGHT    = 2'd2;
  localparam logic [1:0] CORNER_BOTTOM_RIGHT = 2'd3;
  localparam int unsigned MAX_REPORTS        = 30;

  logic signed [COORD_W-1:0] z_origin_q, x_origin_q;
  logic [COORD_W-1:0]        z_inv_q, x_inv_q;
  logic [PTS_W-1:0]          z_pts_q, x_pts_q;
  logic [MARGIN_W-1:0]       margin_q;

  out_item_t corner_q[$];

  task automatic note_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    if (error_count < MAX_REPORTS) begin
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    error_count++;
  endtask

  function automatic logic axis_to_grid(input logic signed [COORD_W-1:0] coord,
                                        input logic signed [COORD_W-1:0] origin,
                                        input logic [COORD_W-1:0] inv,
                                        input logic [PTS_W-1:0] pts,
                                        input logic [MARGIN_W-1:0] mg,
                                        output logic [POS_W-1:0] pos);
    longint      offs;
    longint      lim;
    logic [63:0] prod;
    offs = longint'(coord) - longint'(origin);
    lim  = longint'(pts > MAX_AXIS_POINTS ? MAX_AXIS_POINTS : pts) - 1 - longint'(mg);
    pos  = '0;
    if (offs < 0) return 1'b0;
    prod = 64'(offs) * 64'(inv);
    pos  = prod[STEP_FRAC +: POS_W];
    if (lim <= longint'(mg)) return 1'b0;
    return (pos > (POS_W'(mg) << FRAC_W)) && (pos < (POS_W'(lim) << FRAC_W));
  endfunction

  function automatic logic [WEIGHT_W-1:0] corner_weight(input logic [WEIGHT_W-1:0] a,
                                                        input logic [WEIGHT_W-1:0] b);
    logic [2*WEIGHT_W-1:0] prod;
    prod = a * b + (2*WEIGHT_W)'(1 << (FRAC_W - 1));
    return prod[FRAC_W +: WEIGHT_W];
  endfunction

  task automatic queue_item(input out_item_t item);
    corner_q = {corner_q, item};
  endtask

  task automatic add_corner(input logic [1:0] corner, input longint unsigned index,
                            input logic [WEIGHT_W-1:0] weight, input logic last);
    queue_item('{corner: corner, grid_index: INDEX_W'(index), weight: weight,
                 out_of_bounds: 1'b0, last: last});
  endtask

  task automatic predict_corners(input in_item_t pt);
    logic [POS_W-1:0]    gz, gx;
    logic                z_ok, x_ok;
    longint unsigned     stride, base;
    logic [WEIGHT_W-1:0] fz, fx, wz, wx;
    z_ok = axis_to_grid(pt.z_coord, z_origin_q, z_inv_q, z_pts_q, margin_q, gz);
    x_ok = axis_to_grid(pt.x_coord, x_origin_q, x_inv_q, x_pts_q, margin_q, gx);
    if (!(z_ok && x_ok)) begin
      queue_item('{corner: CORNER_TOP_LEFT, grid_index: '0, weight: '0,
                   out_of_bounds: 1'b1, last: 1'b1});
    end else begin
      stride = (z_pts_q > MAX_AXIS_POINTS) ? MAX_AXIS_POINTS : z_pts_q;
      base   = 64'(gx[POS_W-1:FRAC_W]) * stride + 64'(gz[POS_W-1:FRAC_W]);
      fz     = WEIGHT_W'(gz[FRAC_W-1:0]);
      fx     = WEIGHT_W'(gx[FRAC_W-1:0]);
      wz     = WEIGHT_W'(1 << FRAC_W) - fz;
      wx     = WEIGHT_W'(1 << FRAC_W) - fx;
      add_corner(CORNER_TOP_LEFT, base, corner_weight(wz, wx), 1'b0);
      add_corner(CORNER_BOTTOM_LEFT, base + 1, corner_weight(fz, wx), 1'b0);
      add_corner(CORNER_TOP_RIGHT, base + stride, corner_weight(wz, fx), 1'b0);
      add_corner(CORNER_BOTTOM_RIGHT, base + stride + 1, corner_weight(fz, fx), 1'b1);
    end
  endtask

  task automatic check_corner(input out_item_t got);
    out_item_t want;
    if (corner_q.size() == 0) begin
      note_mismatch("result with nothing expected", got, 0);
      return;
    end
    want = corner_q.pop_front();
    if (got.corner !== want.corner) note_mismatch("corner", got.corner, want.corner);
    if (got.grid_index !== want.grid_index) begin
      note_mismatch("grid_index", got.grid_index, want.grid_index);
    end
    if (got.weight !== want.weight) note_mismatch("weight", got.weight, want.weight);
    if (got.out_of_bounds !== want.out_of_bounds) begin
      note_mismatch("out_of_bounds", got.out_of_bounds, want.out_of_bounds);
    end
    if (got.last !== want.last) note_mismatch("last", got.last, want.last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      z_origin_q  <= '0;
      x_origin_q  <= '0;
      z_inv_q     <= 32'h0001_0000;
      x_inv_q     <= 32'h0001_0000;
      z_pts_q     <= PTS_W'(MAX_AXIS_POINTS);
      x_pts_q     <= PTS_W'(MAX_AXIS_POINTS);
      margin_q    <= MARGIN_W'(1);
      corner_q.delete();
      corners_due <= 0;
    end else begin
      if (out_valid && !out_stall) check_corner(out_data);
      if (in_valid && !in_stall) predict_corners(in_data);
      if (cfg_we) begin
        case (cfg_index)
          CFG_Z_ORIGIN:   z_origin_q <= cfg_data;
          CFG_X_ORIGIN:   x_origin_q <= cfg_data;
          CFG_Z_STEP_INV: z_inv_q    <= cfg_data;
          CFG_X_STEP_INV: x_inv_q    <= cfg_data;
          CFG_Z_POINTS:   z_pts_q    <= cfg_data[PTS_W-1:0];
          CFG_X_POINTS:   x_pts_q    <= cfg_data[PTS_W-1:0];
          CFG_MARGIN:     margin_q   <= cfg_data[MARGIN_W-1:0];
          default: ;
        endcase
      end
      corners_due <= corner_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
// Top of the corner weight generator testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps

module testbench;
  import bcw_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 3'd7;
  localparam int unsigned          QUIET_LIMIT = 2000;

  typedef enum logic [1:0] {
    STALL_OFF,
    STALL_SPARSE,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_Z_ORIGIN;
  logic [COORD_W-1:0]   cfg_data = '0;

  int unsigned corners_due;
  int unsigned error_count;

  logic [COORD_W-1:0]  z_org = '0, x_org = '0;
  logic [COORD_W-1:0]  z_inv = 32'h0001_0000, x_inv = 32'h0001_0000;
  logic [PTS_W-1:0]    z_pts = 13'd4096, x_pts = 13'd4096;
  logic [MARGIN_W-1:0] margin = 4'd1;

  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  stall_mode_t stall_mode = STALL_OFF;
  int unsigned mode_left = 0;
  int unsigned stall_tick = 0;

  bilinear_corner_weight_generator_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bcw_corner_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .corners_due (corners_due),
    .error_count (error_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(3, 0));
      mode_left  <= $urandom_range(200, 30);
    end else begin
      mode_left <= mode_left - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      STALL_OFF:      out_stall <= 1'b0;
      STALL_SPARSE:   out_stall <= ($urandom_range(3, 0) == 0);
      STALL_PERIODIC: out_stall <= (stall_tick % 5 < 2);
      default:        out_stall <= ($urandom_range(3, 0) != 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(9, 1);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(7, 0) == 0) ? 40 : $urandom_range(16, 1);
    end
    burst_left--;
  endtask

  task automatic send_point(input logic [COORD_W-1:0] z, input logic [COORD_W-1:0] x);
    pace_sender();
    in_valid <= 1'b1;
    in_data  <= '{z_coord: z, x_coord: x};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold the sender until every predicted item has come out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (corners_due != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic write_grid(input logic [COORD_W-1:0] zo, input logic [COORD_W-1:0] xo,
                            input logic [COORD_W-1:0] zi, input logic [COORD_W-1:0] xi,
                            input logic [PTS_W-1:0] zp, input logic [PTS_W-1:0] xp,
                            input logic [MARGIN_W-1:0] mg);
    z_org  = zo;
    x_org  = xo;
    z_inv  = zi;
    x_inv  = xi;
    z_pts  = zp;
    x_pts  = xp;
    margin = mg;
    cfg_write(CFG_Z_ORIGIN, zo);
    cfg_write(CFG_X_ORIGIN, xo);
    cfg_write(CFG_Z_STEP_INV, zi);
    cfg_write(CFG_X_STEP_INV, xi);
    cfg_write(CFG_Z_POINTS, {19'($urandom()), zp});
    cfg_write(CFG_X_POINTS, {19'($urandom()), xp});
    cfg_write(CFG_MARGIN, {28'($urandom()), mg});
    cfg_write(CFG_UNUSED, $urandom());
    cfg_we <= 1'b0;
  endtask

  function automatic logic [COORD_W-1:0] pick_origin();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return '0;
      4, 5, 6, 7: return 32'($signed($urandom()) >>> 3);
      8:          return $urandom();
      default:    return $urandom_range(1, 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] pick_inv();
    case ($urandom_range(9, 0))
      0, 1, 2, 3: return 32'h0001_0000;
      4, 5, 6, 7: return $urandom_range(32'h0004_0000, 32'h0000_2000);
      8:          return $urandom_range(32'hFFFF_FFFF, 1);
      default:    return $urandom_range(1, 0) ? 32'h0000_0001 : 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic logic [PTS_W-1:0] pick_points();
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: return PTS_W'($urandom_range(40, 4));
      5, 6:          return PTS_W'($urandom_range(4096, 4));
      7:             return 13'd4096;
      8:             return 13'd4;
      default:       return $urandom_range(1, 0) ? PTS_W'($urandom_range(8191, 4097))
                                                  : PTS_W'($urandom_range(3, 0));
    endcase
  endfunction

  function automatic logic [MARGIN_W-1:0] pick_margin();
    case ($urandom_range(9, 0))
      7:       return $urandom_range(1, 0) ? 4'd8 : 4'd1;
      8:       return 4'd0;
      9:       return MARGIN_W'($urandom_range(15, 9));
      default: return MARGIN_W'($urandom_range(3, 1));
    endcase
  endfunction

  // aim a coordinate at a random cell inside the margins of the current grid, else random
  function automatic logic [COORD_W-1:0] aim_coord(input logic [COORD_W-1:0] origin,
                                                   input logic [COORD_W-1:0] inv,
                                                   input logic [PTS_W-1:0] pts,
                                                   input logic [MARGIN_W-1:0] mg);
    longint lim, slot, pos, offs;
    lim = longint'(pts > MAX_AXIS_POINTS ? MAX_AXIS_POINTS : pts) - 1 - longint'(mg);
    if (lim <= longint'(mg) || inv == 0) return $urandom();
    slot = $urandom_range(32'(lim) - 1, mg);
    pos  = (slot << FRAC_W) | longint'($urandom_range(16'hFFFF, 0));
    if ($urandom_range(7, 0) == 0) pos = slot << FRAC_W;
    offs = (pos << STEP_FRAC) / longint'(inv);
    return 32'(longint'($signed(origin)) + offs);
  endfunction

  task automatic random_point();
    case ($urandom_range(9, 0))
      7:       send_point($urandom(), aim_coord(x_org, x_inv, x_pts, margin));
      8:       send_point(aim_coord(z_org, z_inv, z_pts, margin), $urandom());
      9:       send_point($urandom(), $urandom());
      default: send_point(aim_coord(z_org, z_inv, z_pts, margin),
                          aim_coord(x_org, x_inv, x_pts, margin));
    endcase
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_point(32'h0002_8000, 32'h0003_4000);
    send_point(32'h0001_0000, 32'h0002_0000);
    send_point(32'h0001_0001, 32'h0001_0001);
    send_point(32'h0FFE_0000, 32'h0002_0000);
    send_point(32'h0FFD_FFFF, 32'h0FFD_FFFF);
    send_point(32'h0010_0000, 32'h0020_0000);
    send_point(32'h0020_8000, 32'h0030_8000);
    send_point(32'h0005_FFFF, 32'h0007_FFFF);
    send_point(32'hFFFF_0000, 32'h0005_0000);
    send_point(32'h0005_0000, 32'h8000_0000);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h0AAA_5555, 32'h0555_AAAA);
    drain();

    write_grid(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0001_0000,
               13'd4096, 13'd4096, 4'd1);
    send_point(32'h0004_0000, 32'h0004_0000);
    send_point(32'h7FFF_FFFF, 32'h0004_0000);
    drain();

    write_grid(32'h0100_0000, 32'hFF00_0000, 32'h0001_0000, 32'h0001_0000,
               13'd8191, 13'd5000, 4'd0);
    send_point(32'h0100_8000, 32'hFF00_0001);
    send_point(32'h0100_0000, 32'hFF00_8000);
    send_point(32'h10FE_FFFF, 32'h0EFE_FFFF);
    drain();

    write_grid(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000,
               13'd4, 13'd4, 4'd2);
    send_point(32'h0001_8000, 32'h0001_8000);
    drain();

    write_grid(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000,
               13'd0, 13'd4096, 4'd15);
    send_point(32'h0000_8000, 32'h0100_0000);
    drain();

    write_grid(32'h8000_0000, 32'h7FFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               13'd4, 13'd4, 4'd1);
    send_point(32'h8000_0002, 32'h7FFF_FFF2);
    send_point(32'h8000_0001, 32'h7FFF_FFF2);
    drain();

    write_grid(32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001,
               13'd4096, 13'd4096, 4'd8);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      write_grid(pick_origin(), pick_origin(), pick_inv(), pick_inv(),
                 pick_points(), pick_points(), pick_margin());
      for (int n = 0; n < 19; n++) begin
        if ($urandom_range(39, 0) == 0) drain();
        random_point();
      end
      drain();
    end

    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
